FILE: hdl/vzc_pkg.sv
// Shared types, constants and mapping functions for the varint/zigzag codec.
package vzc_pkg;

    localparam int VZC_QUEUE_DEPTH = 2;

    localparam logic [6:0] VZC_GROUP_MASK = 7'h7F;
    localparam logic [3:0] VZC_LIMIT_NARROW = 4'd5;
    localparam logic [3:0] VZC_LIMIT_WIDE = 4'd10;
    localparam logic [3:0] VZC_MAX_CONT = 4'd9;

    localparam logic VZC_CMD_ENCODE = 1'b0;
    localparam logic VZC_CMD_DECODE = 1'b1;
    localparam logic VZC_KIND_BYTE = 1'b0;
    localparam logic VZC_KIND_VALUE = 1'b1;

    // One queued job: either a mapped value to encode or a finished decode.
    typedef struct packed {
        logic        is_value;
        logic [63:0] data;
    } t_job;

    // One step of the byte emitter.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last;
        logic [63:0] rem;
    } t_enc_step;

    function automatic logic [63:0] zigzag_enc(input logic [63:0] v, input logic wide);
        logic [31:0] n32;
        n32 = {v[30:0], 1'b0} ^ {32{v[31]}};
        if (wide) begin
            return {v[62:0], 1'b0} ^ {64{v[63]}};
        end
        return {32'd0, n32};
    endfunction

    function automatic logic [63:0] zigzag_dec(input logic [63:0] v, input logic wide);
        logic [31:0] r32;
        r32 = {1'b0, v[31:1]} ^ {32{v[0]}};
        if (wide) begin
            return {1'b0, v[63:1]} ^ {64{v[0]}};
        end
        return {{32{r32[31]}}, r32};
    endfunction

    // The tenth byte carries whatever is left, so the count caps continuation.
    function automatic t_enc_step enc_step(input logic [63:0] v, input logic [3:0] n);
        t_enc_step s;
        logic      cont;
        cont = (v[63:7] != 57'd0) && (n < VZC_MAX_CONT);
        s.data_byte = cont ? {1'b1, v[6:0]} : v[7:0];
        s.last = !cont;
        s.rem = {7'd0, v[63:7]};
        return s;
    endfunction

endpackage

FILE: hdl/vzc_front.sv
// Intake: maps values to encode and gathers decode bytes into whole values.
module vzc_front
    import vzc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_cmd,
    input  logic        i_wide,
    input  logic        i_signed_mode,
    input  logic [63:0] i_value_in,
    input  logic [7:0]  i_byte_in,
    output logic        o_push,
    output t_job        o_job
);

    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;

    logic [6:0]  shift;
    logic [63:0] acc_or;
    logic [3:0]  cnt_inc;
    logic [3:0]  limit;
    logic        done;
    logic [63:0] dec_raw;
    logic [63:0] dec_val;
    logic [63:0] enc_in;
    logic [63:0] enc_val;

    assign shift = 7'(r_cnt) * 7'd7;
    // Groups landing past bit 63 fall off the top of the shift.
    assign acc_or = r_acc | ({57'd0, i_byte_in[6:0] & VZC_GROUP_MASK} << shift);
    assign cnt_inc = r_cnt + 4'd1;
    assign limit = i_wide ? VZC_LIMIT_WIDE : VZC_LIMIT_NARROW;
    assign done = !i_byte_in[7] || (cnt_inc >= limit) || (cnt_inc == 4'd0);

    assign dec_raw = i_wide ? acc_or : {32'd0, acc_or[31:0]};
    assign dec_val = i_signed_mode ? zigzag_dec(dec_raw, i_wide) : dec_raw;

    assign enc_in = i_wide ? i_value_in : {32'd0, i_value_in[31:0]};
    assign enc_val = i_signed_mode ? zigzag_enc(enc_in, i_wide) : enc_in;

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        o_push = 1'b0;
        o_job.is_value = 1'b0;
        o_job.data = enc_val;
        if (i_accept) begin
            if (i_cmd == VZC_CMD_DECODE) begin
                o_job.is_value = 1'b1;
                o_job.data = dec_val;
                if (done) begin
                    o_push = 1'b1;
                    n_acc = 64'd0;
                    n_cnt = 4'd0;
                end else begin
                    n_acc = acc_or;
                    n_cnt = cnt_inc;
                end
            end else begin
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 64'd0;
            r_cnt <= 4'd0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < VZC_LIMIT_WIDE)
        else $error("decode group count passed the wide limit");

endmodule

FILE: hdl/vzc_queue.sv
// Small job queue between intake and emitter.
module vzc_queue
    import vzc_pkg::*;
#(
    parameter int DEPTH = VZC_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;

    assign o_empty = (r_count == CW'(0));
    assign o_full = (r_count == CW'(DEPTH));
    assign o_head = r_mem[r_rp];

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? AW'(0) : r_wp + AW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? AW'(0) : r_rp + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_count <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");

endmodule

FILE: hdl/vzc_back.sv
// Emitter: turns queued jobs into byte or value result beats.
module vzc_back
    import vzc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [7:0]  o_byte_out,
    output logic        o_last,
    output logic [63:0] o_value_out
);

    logic        r_ov, n_ov;
    logic        r_more, n_more;
    logic [3:0]  r_n, n_n;
    logic [63:0] r_rem, n_rem;
    logic        r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic [63:0] r_value, n_value;

    t_enc_step   st_cont;
    t_enc_step   st_first;
    logic        load;

    assign st_cont = enc_step(r_rem, r_n);
    assign st_first = enc_step(i_head.data, 4'd0);
    assign load = !r_ov || !i_stall;

    always_comb begin
        n_ov = r_ov;
        n_more = r_more;
        n_n = r_n;
        n_rem = r_rem;
        n_kind = r_kind;
        n_byte = r_byte;
        n_last = r_last;
        n_value = r_value;
        o_pop = 1'b0;
        if (load) begin
            if (r_ov && r_more) begin
                n_ov = 1'b1;
                n_kind = VZC_KIND_BYTE;
                n_byte = st_cont.data_byte;
                n_last = st_cont.last;
                n_value = 64'd0;
                n_rem = st_cont.rem;
                n_n = r_n + 4'd1;
                n_more = !st_cont.last;
            end else if (!i_empty) begin
                o_pop = 1'b1;
                n_ov = 1'b1;
                if (i_head.is_value) begin
                    n_kind = VZC_KIND_VALUE;
                    n_byte = 8'd0;
                    n_last = 1'b1;
                    n_value = i_head.data;
                    n_more = 1'b0;
                    n_n = 4'd0;
                end else begin
                    n_kind = VZC_KIND_BYTE;
                    n_byte = st_first.data_byte;
                    n_last = st_first.last;
                    n_value = 64'd0;
                    n_rem = st_first.rem;
                    n_n = 4'd1;
                    n_more = !st_first.last;
                end
            end else begin
                n_ov = 1'b0;
                n_more = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_more <= 1'b0;
            r_n <= 4'd0;
        end else begin
            r_ov <= n_ov;
            r_more <= n_more;
            r_n <= n_n;
        end
        r_rem <= n_rem;
        r_kind <= n_kind;
        r_byte <= n_byte;
        r_last <= n_last;
        r_value <= n_value;
    end

    assign o_valid = r_ov;
    assign o_kind = r_kind;
    assign o_byte_out = r_byte;
    assign o_last = r_last;
    assign o_value_out = r_value;

    a_value_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind == VZC_KIND_VALUE) |-> (r_last && !r_more))
        else $error("decoded value beat not marked last");

    a_cont_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind == VZC_KIND_BYTE) |-> (r_byte[7] == !r_last) && (r_more == !r_last))
        else $error("continuation bit disagrees with last marker");

    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_more |-> (r_n <= VZC_MAX_CONT))
        else $error("encoded run longer than ten bytes");

endmodule

FILE: hdl/varint_zigzag_codec.sv
// Top level of the varint/zigzag codec: intake, job queue and emitter.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------------
//   in      | input     | i_in_valid / o_in_stall  | cmd, wide, signed_mode, value_in, byte_in
//   out     | output    | o_out_valid / i_out_stall| kind, byte_out, last, value_out
//
// A decode beat feeds the accumulator; a finished value is queued, then held in the emitter.
// An encode beat becomes 1 to 10 byte beats, one per unstalled cycle, via the step register.
// Intake stalls only when the job queue (QUEUE_DEPTH jobs) is full.
// Synchronous active-low reset clears the decode accumulator, the queue and the output.
// Output beats hold while i_out_stall is high.
module varint_zigzag_codec
    import vzc_pkg::*;
#(
    parameter int QUEUE_DEPTH = VZC_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic        i_wide,
    input  logic        i_signed_mode,
    input  logic [63:0] i_value_in,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_byte_out,
    output logic        o_last,
    output logic [63:0] o_value_out
);

    logic accept;
    logic push;
    t_job job;
    logic pop;
    t_job head;
    logic empty;
    logic full;

    assign o_in_stall = full;
    assign accept = i_in_valid && !full;

    vzc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_wide        (i_wide),
        .i_signed_mode (i_signed_mode),
        .i_value_in    (i_value_in),
        .i_byte_in     (i_byte_in),
        .o_push        (push),
        .o_job         (job)
    );

    vzc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    vzc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_kind      (o_kind),
        .o_byte_out  (o_byte_out),
        .o_last      (o_last),
        .o_value_out (o_value_out)
    );

endmodule
